/* design/eau_pkg.sv */
package eau_pkg;

	localparam int unsigned NUM_REGS = 17;
	localparam int unsigned RF_AW = 5;
	localparam logic [RF_AW-1:0] SSP_SLOT = 5'd16;
	localparam logic [RF_AW-1:0] AREG_BASE = 5'd8;

	typedef enum logic {
		MODE_EA   = 1'b0,
		MODE_LOAD = 1'b1
	} mode_e;

	typedef enum logic [3:0] {
		EA_NONE   = 4'd0,
		EA_IND    = 4'd1,
		EA_POSTI  = 4'd2,
		EA_PRED   = 4'd3,
		EA_D16AN  = 4'd4,
		EA_IDXAN  = 4'd5,
		EA_ABSW   = 4'd6,
		EA_ABSL   = 4'd7,
		EA_D16PC  = 4'd8,
		EA_IDXPC  = 4'd9,
		EA_IMM    = 4'd10,
		EA_BCC    = 4'd11,
		EA_DBCC   = 4'd12
	} ea_kind_e;

	typedef struct packed {
		logic        mode;
		logic [3:0]  ea_kind;
		logic [4:0]  reg_num;
		logic [2:0]  size_bytes;
		logic        supervisor;
		logic [31:0] pc;
		logic [15:0] ext_word;
		logic [15:0] ext_word_low;
		logic [7:0]  branch_disp8;
		logic        commit_update;
		logic        ext_fault;
		logic [31:0] reg_value;
	} req_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] next_pc;
		logic [3:0]  cycles_added;
		logic        fault;
	} rsp_t;

	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] addr;
		logic [31:0]      data;
	} rf_wr_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [RF_AW-1:0] areg_slot(input logic [2:0] r, input logic sup);
		logic [RF_AW-1:0] slot;
		slot = AREG_BASE + {2'b00, r};
		if (r == 3'd7 && sup) begin
			slot = SSP_SLOT;
		end
		return slot;
	endfunction

	function automatic logic [RF_AW-1:0] index_slot(input logic [15:0] brief, input logic sup);
		logic [RF_AW-1:0] slot;
		slot = {2'b00, brief[14:12]};
		if (brief[15]) begin
			slot = areg_slot(brief[14:12], sup);
		end
		return slot;
	endfunction

endpackage

/* design/eau_ifs.sv */
interface eau_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [3:0]  ea_kind;
	logic [4:0]  reg_num;
	logic [2:0]  size_bytes;
	logic        supervisor;
	logic [31:0] pc;
	logic [15:0] ext_word;
	logic [15:0] ext_word_low;
	logic [7:0]  branch_disp8;
	logic        commit_update;
	logic        ext_fault;
	logic [31:0] reg_value;

	modport source(output valid, mode, ea_kind, reg_num, size_bytes, supervisor, pc,
		ext_word, ext_word_low, branch_disp8, commit_update, ext_fault, reg_value,
		input ready);
	modport sink(input valid, mode, ea_kind, reg_num, size_bytes, supervisor, pc,
		ext_word, ext_word_low, branch_disp8, commit_update, ext_fault, reg_value,
		output ready);
endinterface

interface eau_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [31:0] next_pc;
	logic [3:0]  cycles_added;
	logic        fault;

	modport source(output valid, address, next_pc, cycles_added, fault, input ready);
	modport sink(input valid, address, next_pc, cycles_added, fault, output ready);
endinterface

/* design/eau_regfile.sv */
module eau_regfile import eau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [RF_AW-1:0] rd_addr_a,
	input  logic [RF_AW-1:0] rd_addr_b,
	input  rf_wr_t           wr,
	output logic [31:0]      rd_data_a,
	output logic [31:0]      rd_data_b
);

	logic [31:0]         mem [NUM_REGS];
	logic [NUM_REGS-1:0] ent_vld_q;
	logic [31:0]         dat_a_q;
	logic [31:0]         dat_b_q;
	logic                ok_a_q;
	logic                ok_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			dat_a_q <= mem[rd_addr_a];
			dat_b_q <= mem[rd_addr_b];
		end
	end

	// Entries never written read as zero, which matches the reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			ok_a_q    <= 1'b0;
			ok_b_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				ent_vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				ok_a_q <= ent_vld_q[rd_addr_a];
				ok_b_q <= ent_vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = ok_a_q ? dat_a_q : '0;
	assign rd_data_b = ok_b_q ? dat_b_q : '0;

endmodule

/* design/eau_calc.sv */
module eau_calc import eau_pkg::*; (
	input  req_t        req,
	input  logic [31:0] base_val,
	input  logic [31:0] index_raw,
	output rsp_t        rsp,
	output rf_wr_t      wr
);

	logic [31:0]      step;
	logic [31:0]      index_val;
	logic [31:0]      base_sel;
	logic [RF_AW-1:0] slot;

	always_comb begin
		slot = areg_slot(req.reg_num[2:0], req.supervisor);
		if (req.reg_num[2:0] == 3'd7) begin
			step = (req.size_bytes == 3'd4) ? 32'd4 : 32'd2;
		end else begin
			step = {29'd0, req.size_bytes};
		end
		index_val = req.ext_word[11] ? index_raw : sx16(index_raw[15:0]);
		base_sel = (req.ea_kind == EA_D16AN || req.ea_kind == EA_IDXAN) ? base_val : req.pc;

		rsp.address      = '0;
		rsp.next_pc      = req.pc;
		rsp.cycles_added = 4'd0;
		rsp.fault        = 1'b0;
		wr.en            = 1'b0;
		wr.addr          = slot;
		wr.data          = '0;

		if (req.mode == MODE_LOAD) begin
			wr.en   = (req.reg_num <= SSP_SLOT);
			wr.addr = req.reg_num;
			wr.data = req.reg_value;
		end else begin
			case (req.ea_kind)
				EA_IND: begin
					rsp.address = base_val;
				end
				EA_POSTI: begin
					rsp.address = base_val;
					wr.en       = req.commit_update;
					wr.data     = base_val + step;
				end
				EA_PRED: begin
					rsp.address      = base_val - step;
					rsp.cycles_added = 4'd2;
					wr.en            = req.commit_update;
					wr.data          = base_val - step;
				end
				EA_D16AN, EA_D16PC, EA_DBCC: begin
					rsp.cycles_added = 4'd4;
					if (req.ext_fault) begin
						rsp.fault = 1'b1;
					end else begin
						rsp.address = base_sel + sx16(req.ext_word);
						rsp.next_pc = req.pc + 32'd2;
					end
				end
				EA_IDXAN, EA_IDXPC: begin
					rsp.cycles_added = 4'd4;
					if (req.ext_fault) begin
						rsp.fault = 1'b1;
					end else begin
						rsp.cycles_added = 4'd6;
						rsp.address = base_sel + sx8(req.ext_word[7:0]) + index_val;
						rsp.next_pc = req.pc + 32'd2;
					end
				end
				EA_ABSW: begin
					rsp.cycles_added = 4'd4;
					if (req.ext_fault) begin
						rsp.fault = 1'b1;
					end else begin
						rsp.address = sx16(req.ext_word);
						rsp.next_pc = req.pc + 32'd2;
					end
				end
				EA_ABSL: begin
					rsp.cycles_added = 4'd8;
					if (req.ext_fault) begin
						rsp.fault = 1'b1;
					end else begin
						rsp.address = {req.ext_word, req.ext_word_low};
						rsp.next_pc = req.pc + 32'd4;
					end
				end
				EA_IMM: begin
					rsp.address = req.pc;
					rsp.next_pc = req.pc + ((req.size_bytes == 3'd4) ? 32'd4 : 32'd2);
				end
				EA_BCC: begin
					if (req.branch_disp8 != 8'd0) begin
						rsp.address = req.pc + sx8(req.branch_disp8);
					end else if (req.ext_fault) begin
						rsp.fault = 1'b1;
					end else begin
						rsp.address = req.pc + sx16(req.ext_word);
						rsp.next_pc = req.pc + 32'd2;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/effective_address_unit.sv */
// Channel  Dir  Payload
// req      in   mode, ea_kind, reg_num, size_bytes, supervisor, pc, ext_word,
//                ext_word_low, branch_disp8, commit_update, ext_fault, reg_value
// rsp      out  address, next_pc, cycles_added, fault
//
// One request is taken every cycle unless a stalled response holds stage two;
// request and register file read are registered into stage two, its result
// into rsp_q; a write in the same cycle as that read is forwarded to stage two.
// Reset clears all control state; the register file reads as zero until written.
// A stalled response holds the second stage, and req.ready drops only then.
module effective_address_unit import eau_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	eau_req_if.sink     req,
	eau_rsp_if.source   rsp
);

	req_t        req_in;
	req_t        req_s1;
	logic        s1_valid_q;
	logic        s1_fire;
	logic        in_acc;
	rf_wr_t      rf_wr;
	rf_wr_t      fwd_q;
	logic [31:0] rd_a;
	logic [31:0] rd_b;
	logic [31:0] base_val;
	logic [31:0] index_raw;
	rsp_t        result;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	assign req_in = '{
		mode:          req.mode,
		ea_kind:       req.ea_kind,
		reg_num:       req.reg_num,
		size_bytes:    req.size_bytes,
		supervisor:    req.supervisor,
		pc:            req.pc,
		ext_word:      req.ext_word,
		ext_word_low:  req.ext_word_low,
		branch_disp8:  req.branch_disp8,
		commit_update: req.commit_update,
		ext_fault:     req.ext_fault,
		reg_value:     req.reg_value
	};

	assign s1_fire   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_fire;
	assign in_acc    = req.valid && req.ready;

	eau_regfile u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_acc),
		.rd_addr_a (areg_slot(req.reg_num[2:0], req.supervisor)),
		.rd_addr_b (index_slot(req.ext_word, req.supervisor)),
		.wr        (rf_wr),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_comb begin
		base_val = rd_a;
		if (fwd_q.en && fwd_q.addr == areg_slot(req_s1.reg_num[2:0], req_s1.supervisor)) begin
			base_val = fwd_q.data;
		end
		index_raw = rd_b;
		if (fwd_q.en && fwd_q.addr == index_slot(req_s1.ext_word, req_s1.supervisor)) begin
			index_raw = fwd_q.data;
		end
	end

	rf_wr_t calc_wr;

	eau_calc u_calc (
		.req       (req_s1),
		.base_val  (base_val),
		.index_raw (index_raw),
		.rsp       (result),
		.wr        (calc_wr)
	);

	always_comb begin
		rf_wr    = calc_wr;
		rf_wr.en = calc_wr.en && s1_fire;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= req_in;
		end
		if (s1_fire) begin
			rsp_q <= result;
		end
	end

	// The write made at the edge where a request enters the second stage was
	// missed by its read, so it is kept until the next request enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			fwd_q       <= '0;
		end else begin
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (in_acc) begin
				fwd_q <= rf_wr;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.address      = rsp_q.address;
	assign rsp.next_pc      = rsp_q.next_pc;
	assign rsp.cycles_added = rsp_q.cycles_added;
	assign rsp.fault        = rsp_q.fault;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted request did not reach the second stage");

	a_fire_drains_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !in_acc |=> !s1_valid_q)
		else $error("second stage kept a request that already wrote back");

	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp.valid)
		else $error("second stage fired without a response");

	a_fwd_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(fwd_q))
		else $error("forward record changed without a new request");

endmodule

/* test/effective_address_unit_tb.sv */
module effective_address_unit_tb;
	import eau_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_REQS = 400;

	typedef struct {
		req_t item;
		bit   drain;
	} pending_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eau_req_if req_bus();
	eau_rsp_if rsp_bus();

	effective_address_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	req_t drv_item = '0;
	logic item_valid = 1'b0;
	logic rsp_ready = 1'b0;

	assign req_bus.valid         = item_valid;
	assign req_bus.mode          = drv_item.mode;
	assign req_bus.ea_kind       = drv_item.ea_kind;
	assign req_bus.reg_num       = drv_item.reg_num;
	assign req_bus.size_bytes    = drv_item.size_bytes;
	assign req_bus.supervisor    = drv_item.supervisor;
	assign req_bus.pc            = drv_item.pc;
	assign req_bus.ext_word      = drv_item.ext_word;
	assign req_bus.ext_word_low  = drv_item.ext_word_low;
	assign req_bus.branch_disp8  = drv_item.branch_disp8;
	assign req_bus.commit_update = drv_item.commit_update;
	assign req_bus.ext_fault     = drv_item.ext_fault;
	assign req_bus.reg_value     = drv_item.reg_value;
	assign rsp_bus.ready         = rsp_ready;

	pending_req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	logic [31:0] shadow_regs [NUM_REGS];
	int errors = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic rsp_t compute_ea(input req_t r);
		rsp_t o;
		logic [RF_AW-1:0] slot;
		logic [RF_AW-1:0] xslot;
		logic [31:0] step;
		logic [31:0] base;
		logic [31:0] idx;
		o.address = '0;
		o.next_pc = r.pc;
		o.cycles_added = '0;
		o.fault = 1'b0;
		slot = (r.reg_num[2:0] == 3'd7 && r.supervisor) ? SSP_SLOT : AREG_BASE + r.reg_num[2:0];
		if (r.reg_num[2:0] == 3'd7) begin
			step = (r.size_bytes == 3'd4) ? 32'd4 : 32'd2;
		end else begin
			step = {29'd0, r.size_bytes};
		end
		if (r.mode == MODE_LOAD) begin
			if (r.reg_num < NUM_REGS) begin
				shadow_regs[r.reg_num] = r.reg_value;
			end
		end else begin
			case (ea_kind_e'(r.ea_kind))
				EA_IND: begin
					o.address = shadow_regs[slot];
				end
				EA_POSTI: begin
					o.address = shadow_regs[slot];
					if (r.commit_update) begin
						shadow_regs[slot] = o.address + step;
					end
				end
				EA_PRED: begin
					o.address = shadow_regs[slot] - step;
					o.cycles_added = 4'd2;
					if (r.commit_update) begin
						shadow_regs[slot] = o.address;
					end
				end
				EA_D16AN, EA_D16PC: begin
					o.cycles_added = 4'd4;
					base = (r.ea_kind == EA_D16AN) ? shadow_regs[slot] : r.pc;
					if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.address = base + {{16{r.ext_word[15]}}, r.ext_word};
						o.next_pc = r.pc + 32'd2;
					end
				end
				EA_IDXAN, EA_IDXPC: begin
					o.cycles_added = 4'd4;
					base = (r.ea_kind == EA_IDXAN) ? shadow_regs[slot] : r.pc;
					if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.cycles_added = 4'd6;
						xslot = {2'b00, r.ext_word[14:12]};
						if (r.ext_word[15]) begin
							xslot = (r.ext_word[14:12] == 3'd7 && r.supervisor) ? SSP_SLOT :
								AREG_BASE + r.ext_word[14:12];
						end
						idx = shadow_regs[xslot];
						if (!r.ext_word[11]) begin
							idx = {{16{idx[15]}}, idx[15:0]};
						end
						o.address = base + {{24{r.ext_word[7]}}, r.ext_word[7:0]} + idx;
						o.next_pc = r.pc + 32'd2;
					end
				end
				EA_ABSW: begin
					o.cycles_added = 4'd4;
					if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.address = {{16{r.ext_word[15]}}, r.ext_word};
						o.next_pc = r.pc + 32'd2;
					end
				end
				EA_ABSL: begin
					o.cycles_added = 4'd8;
					if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.address = {r.ext_word, r.ext_word_low};
						o.next_pc = r.pc + 32'd4;
					end
				end
				EA_IMM: begin
					o.address = r.pc;
					o.next_pc = r.pc + ((r.size_bytes == 3'd4) ? 32'd4 : 32'd2);
				end
				EA_BCC: begin
					if (r.branch_disp8 != 8'd0) begin
						o.address = r.pc + {{24{r.branch_disp8[7]}}, r.branch_disp8};
					end else if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.address = r.pc + {{16{r.ext_word[15]}}, r.ext_word};
						o.next_pc = r.pc + 32'd2;
					end
				end
				EA_DBCC: begin
					o.cycles_added = 4'd4;
					if (r.ext_fault) begin
						o.fault = 1'b1;
					end else begin
						o.address = r.pc + {{16{r.ext_word[15]}}, r.ext_word};
						o.next_pc = r.pc + 32'd2;
					end
				end
				default: begin
				end
			endcase
		end
		return o;
	endfunction

	function automatic req_t random_ea_req();
		req_t r;
		r.mode = MODE_EA;
		r.ea_kind = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15)) :
			4'($urandom_range(0, 12));
		r.reg_num = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0, 1: r.size_bytes = 3'd1;
			2, 3: r.size_bytes = 3'd2;
			4, 5: r.size_bytes = 3'd4;
			default: r.size_bytes = 3'($urandom_range(0, 7));
		endcase
		r.supervisor = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: r.pc = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
			1: r.pc = 32'($urandom_range(0, 15));
			default: r.pc = $urandom;
		endcase
		r.ext_word = 16'($urandom);
		r.ext_word_low = 16'($urandom);
		r.branch_disp8 = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
		r.commit_update = 1'($urandom_range(0, 3) != 0);
		r.ext_fault = 1'($urandom_range(0, 5) == 0);
		r.reg_value = $urandom;
		return r;
	endfunction

	function automatic req_t load_req(input logic [4:0] num, input logic [31:0] value);
		req_t r;
		r = random_ea_req();
		r.mode = MODE_LOAD;
		r.reg_num = num;
		r.reg_value = value;
		return r;
	endfunction

	task automatic queue_req(input req_t r, input bit drain);
		pending_req_t p;
		p.item = r;
		p.drain = drain;
		pending_reqs.push_back(p);
	endtask

	task automatic queue_ea(input ea_kind_e kind, input logic [4:0] num, input logic [2:0] size,
			input logic sup, input logic commit, input logic flt, input logic [31:0] pc,
			input logic [15:0] ew, input logic [7:0] d8);
		req_t r;
		r = random_ea_req();
		r.ea_kind = kind;
		r.reg_num = num;
		r.size_bytes = size;
		r.supervisor = sup;
		r.commit_update = commit;
		r.ext_fault = flt;
		r.pc = pc;
		r.ext_word = ew;
		r.branch_disp8 = d8;
		queue_req(r, 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int gap_left;
		int burst_left;
		logic next_valid;
		if (!arst_n) begin
			item_valid <= 1'b0;
			drv_item <= '0;
			gap_left = 0;
			burst_left = 0;
			for (int i = 0; i < NUM_REGS; i++) begin
				shadow_regs[i] = '0;
			end
		end else begin
			next_valid = item_valid;
			if (item_valid && req_bus.ready) begin
				expected_rsps.push_back(compute_ea(drv_item));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0 &&
						!(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
					drv_item <= pending_reqs[0].item;
					pending_reqs.pop_front();
					next_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			item_valid <= next_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int stall_left;
		int unsigned cycle_count;
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
			cycle_count = 0;
		end else begin
			if (rsp_bus.valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response: address %h", rsp_bus.address);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_bus.address !== want.address) begin
						$error("address: expected %h, got %h", want.address, rsp_bus.address);
						errors++;
					end
					if (rsp_bus.next_pc !== want.next_pc) begin
						$error("next_pc: expected %h, got %h", want.next_pc, rsp_bus.next_pc);
						errors++;
					end
					if (rsp_bus.cycles_added !== want.cycles_added) begin
						$error("cycles_added: expected %0d, got %0d", want.cycles_added,
							rsp_bus.cycles_added);
						errors++;
					end
					if (rsp_bus.fault !== want.fault) begin
						$error("fault: expected %b, got %b", want.fault, rsp_bus.fault);
						errors++;
					end
				end
			end
			cycle_count++;
			if (cycle_count[8:7] == 2'b00) begin
				rsp_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		int unsigned idle_cycles;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((item_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		req_t r;
		queue_req(load_req(5'd0, 32'hFFFF_FFFF), 1'b0);
		queue_req(load_req(5'd5, 32'h0000_8000), 1'b0);
		queue_req(load_req(5'd10, 32'h0000_1000), 1'b0);
		queue_req(load_req(5'd15, 32'h0000_0001), 1'b0);
		queue_req(load_req(SSP_SLOT, 32'hFFFF_FFFF), 1'b0);
		queue_req(load_req(5'd31, 32'h1234_5678), 1'b0);
		queue_ea(EA_NONE, 5'd2, 3'd4, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 16'hFFFF, 8'h00);
		queue_ea(EA_IND, 5'd2, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_POSTI, 5'd7, 3'd1, 1'b0, 1'b1, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_POSTI, 5'd7, 3'd1, 1'b1, 1'b1, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_PRED, 5'd7, 3'd4, 1'b1, 1'b1, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_PRED, 5'd2, 3'd3, 1'b0, 1'b1, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_POSTI, 5'd1, 3'd0, 1'b0, 1'b1, 1'b0, 32'h0000_0100, 16'h0000, 8'h01);
		queue_ea(EA_D16AN, 5'd2, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0000_0200, 16'h8000, 8'h01);
		queue_ea(EA_IDXAN, 5'd2, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0000_0200, 16'h5080, 8'h01);
		queue_ea(EA_IDXPC, 5'd0, 3'd2, 1'b1, 1'b0, 1'b0, 32'h8000_0000, 16'hF8FF, 8'h01);
		queue_ea(EA_ABSW, 5'd0, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0000_0300, 16'hFFFF, 8'h01);
		queue_ea(EA_ABSL, 5'd0, 3'd4, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFC, 16'hFFFF, 8'h01);
		queue_ea(EA_D16PC, 5'd0, 3'd2, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFE, 16'h7FFF, 8'h01);
		queue_ea(EA_IMM, 5'd0, 3'd4, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFE, 16'h0000, 8'h01);
		queue_ea(EA_IMM, 5'd0, 3'd1, 1'b0, 1'b0, 1'b0, 32'h0000_0400, 16'h0000, 8'h01);
		queue_ea(EA_BCC, 5'd0, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0000_0400, 16'h8000, 8'h00);
		queue_ea(EA_BCC, 5'd0, 3'd2, 1'b0, 1'b0, 1'b1, 32'h0000_0400, 16'h0000, 8'hFF);
		queue_ea(EA_DBCC, 5'd0, 3'd2, 1'b0, 1'b0, 1'b1, 32'h0000_0400, 16'h0010, 8'h00);
		queue_ea(EA_IDXAN, 5'd3, 3'd2, 1'b0, 1'b0, 1'b1, 32'h0000_0400, 16'h0010, 8'h00);
		queue_ea(ea_kind_e'(4'd15), 5'd3, 3'd7, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'h1, 8'h0);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				r = load_req(($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31)) :
					5'($urandom_range(0, 16)), $urandom);
			end else begin
				r = random_ea_req();
			end
			queue_req(r, n % 100 == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || item_valid) begin
			@(posedge clk);
		end
		while (expected_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
design/eau_pkg.sv
design/eau_ifs.sv
design/eau_regfile.sv
design/eau_calc.sv
design/effective_address_unit.sv
test/effective_address_unit_tb.sv
